### sv/aoi_pkg.sv
package aoi_pkg;

   localparam int MaxAreasDefault    = 16;
   localparam int MaxVerticesDefault = 1024;
   localparam int CoordBits          = 24;

   // operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_OPEN   = 2'd1;
   localparam logic [1:0] OP_VERTEX = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_AREA_FULL = 2'd1;
   localparam logic [1:0] ST_VERT_FULL = 2'd2;
   localparam logic [1:0] ST_NO_AREA   = 2'd3;

   typedef struct packed {
      logic [1:0]                  operation;
      logic signed [CoordBits-1:0] coord_x;
      logic signed [CoordBits-1:0] coord_y;
      logic signed [CoordBits-1:0] box_right;
      logic signed [CoordBits-1:0] box_bottom;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [3:0] area_index;
      logic [1:0] status;
   } rsp_type;

endpackage

### sv/aoi_edge_test.sv
// crossing test for one edge, two stages: differences, products, compare
module aoi_edge_test
   import aoi_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        edge_valid,
   input  logic signed [CoordBits-1:0] px,
   input  logic signed [CoordBits-1:0] py,
   input  logic signed [CoordBits-1:0] ax,
   input  logic signed [CoordBits-1:0] ay,
   input  logic signed [CoordBits-1:0] bx,
   input  logic signed [CoordBits-1:0] by,
   output logic                        cross_valid,
   output logic                        crossing
);
   localparam int DW = CoordBits + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] dpx_ff, dpy_ff, dbx_ff, dy_ff;
   logic                 span_ff, v1_ff, v2_ff, cross_ff;
   logic signed [PW-1:0] lhs, rhs;
   logic                 straddle;

   assign straddle = (ay > py) != (by > py);

   // stage one: differences and straddle check
   always_ff @(posedge clock) begin
      dpx_ff  <= DW'(px) - DW'(ax);
      dpy_ff  <= DW'(py) - DW'(ay);
      dbx_ff  <= DW'(bx) - DW'(ax);
      dy_ff   <= DW'(by) - DW'(ay);
      span_ff <= straddle;
   end

   // exact compare of cross products, sides swapped for falling edges
   always_comb begin
      if (dy_ff > 0) begin
         lhs = PW'(dpx_ff) * PW'(dy_ff);
         rhs = PW'(dbx_ff) * PW'(dpy_ff);
      end else begin
         lhs = PW'(dbx_ff) * PW'(dpy_ff);
         rhs = PW'(dpx_ff) * PW'(dy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= edge_valid;
         v2_ff <= v1_ff;
      end
      cross_ff <= span_ff && (lhs < rhs);
   end

   assign cross_valid = v2_ff;
   assign crossing    = cross_ff;
endmodule

### sv/area_of_interest_hit_test.sv
// channel | ports              | direction | meaning
// req     | start, busy, req_* | in (busy out) | load command or query point
// rsp     | rsp_strobe, rsp_*  | out       | found, area index, status
//
// a load goes from acceptance to the done state, which registers its result strobe.
// a query walks the areas in order; an area whose box holds the point and that has
// vertices adds a priming step, a step per vertex (single read port of the vertex
// memory) and a drain of the edge pipeline. the walk ends in the done state too.
// reset clears the area and vertex counts and the sequencer, not the tables.
// busy is high from acceptance until the result strobe; the receiver cannot stall.
module area_of_interest_hit_test
   import aoi_pkg::*;
#(
   parameter int MAX_AREAS    = MaxAreasDefault,
   parameter int MAX_VERTICES = MaxVerticesDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);
   localparam int AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
   localparam int AC = $clog2(MAX_AREAS + 1);
   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int VC = $clog2(MAX_VERTICES + 1);
   localparam int CB = CoordBits;

   localparam logic [2:0] S_IDLE = 3'd0, S_AREA = 3'd1, S_BOX = 3'd2,
                          S_PRIME = 3'd3, S_EDGE = 3'd4, S_DRAIN = 3'd5,
                          S_DONE = 3'd6;

   // area table and vertex store
   logic [4*CB-1:0] box_mem [MAX_AREAS];
   logic [VC+VW-1:0] span_mem [MAX_AREAS];
   logic [2*CB-1:0] vert_mem [MAX_VERTICES];

   logic [2:0]    state_ff, state_in;
   logic [AC-1:0] area_count_ff;
   logic [VC-1:0] vertex_count_ff, last_total_ff;
   req_type       req_ff;
   logic [AC-1:0] area_ff;
   logic [VC-1:0] k_ff, total_ff;
   logic [VW-1:0] first_ff;
   logic [4*CB-1:0] box_rd_ff;
   logic [VC+VW-1:0] span_rd_ff;
   logic [2*CB-1:0] vert_rd_ff, a_ff, first_pt_ff;
   logic          vfirst_ff, inside_ff, edge_go_ff;
   logic [1:0]    pend_ff;
   logic          cross_valid, edge_cross;
   logic [VW-1:0] vaddr;
   logic [VC:0]   vsum;
   logic          in_box;
   logic [1:0]    load_status;

   assign busy = state_ff != S_IDLE;

   function automatic logic [VW-1:0] span_rd_first();
      return VW'(vertex_count_ff - last_total_ff);
   endfunction

   // status of the item on the request ports
   always_comb begin
      load_status = ST_OK;
      case (req_item.operation)
         OP_OPEN:
            if (area_count_ff >= AC'(MAX_AREAS)) load_status = ST_AREA_FULL;
         OP_VERTEX:
            if (area_count_ff == 0) load_status = ST_NO_AREA;
            else if (vertex_count_ff >= VC'(MAX_VERTICES)) load_status = ST_VERT_FULL;
         default: ;
      endcase
   end

   // table writes on loads
   always_ff @(posedge clock) begin
      if (start && !busy && req_item.operation == OP_OPEN
          && area_count_ff < AC'(MAX_AREAS)) begin
         box_mem[area_count_ff[AW-1:0]] <= {req_item.coord_x, req_item.coord_y,
                                            req_item.box_right, req_item.box_bottom};
         span_mem[area_count_ff[AW-1:0]] <= {VC'(0), vertex_count_ff[VW-1:0]};
      end
      if (start && !busy && req_item.operation == OP_VERTEX && area_count_ff != 0
          && vertex_count_ff < VC'(MAX_VERTICES)) begin
         vert_mem[vertex_count_ff[VW-1:0]] <= {req_item.coord_x, req_item.coord_y};
         span_mem[AW'(area_count_ff - 1'b1)] <=
            {VC'(last_total_ff + 1'b1), span_rd_first()};
      end
   end

   // vertex read address: the area's first vertex plus the walk index
   assign vsum  = (VC+1)'(first_ff) + (VC+1)'(k_ff);
   assign vaddr = vsum[VW-1:0];

   always_ff @(posedge clock) begin
      box_rd_ff  <= box_mem[area_ff[AW-1:0]];
      span_rd_ff <= span_mem[area_ff[AW-1:0]];
      vert_rd_ff <= vert_mem[vaddr];
   end

   assign in_box =
      $signed(req_ff.coord_x) >= $signed(box_rd_ff[4*CB-1:3*CB]) &&
      $signed(req_ff.coord_y) >= $signed(box_rd_ff[3*CB-1:2*CB]) &&
      $signed(req_ff.coord_x) <= $signed(box_rd_ff[2*CB-1:CB]) &&
      $signed(req_ff.coord_y) <= $signed(box_rd_ff[CB-1:0]);

   // edge pipeline: edge from previous vertex a to current b
   aoi_edge_test u_edge (
      .clock(clock), .reset(reset), .edge_valid(edge_go_ff),
      .px(req_ff.coord_x), .py(req_ff.coord_y),
      .ax(a_ff[2*CB-1:CB]), .ay(a_ff[CB-1:0]),
      .bx(vfirst_ff ? first_pt_ff[2*CB-1:CB] : vert_rd_ff[2*CB-1:CB]),
      .by(vfirst_ff ? first_pt_ff[CB-1:0] : vert_rd_ff[CB-1:0]),
      .cross_valid(cross_valid), .crossing(edge_cross));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = (req_item.operation == OP_QUERY) ? S_AREA : S_DONE;
         S_AREA:  state_in = (area_ff >= area_count_ff) ? S_DONE : S_BOX;
         S_BOX:   state_in = (in_box && span_rd_ff[VC+VW-1:VW] != 0) ? S_PRIME : S_AREA;
         S_PRIME: state_in = S_EDGE;
         S_EDGE:  state_in = (k_ff == total_ff) ? S_DRAIN : S_EDGE;
         S_DRAIN:
            if (pend_ff == 0 && !edge_go_ff && !cross_valid)
               state_in = inside_ff ? S_DONE : S_AREA;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer: area walk, vertex walk, result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         area_count_ff   <= '0;
         vertex_count_ff <= '0;
         last_total_ff   <= '0;
         rsp_strobe      <= 1'b0;
         edge_go_ff      <= 1'b0;
         pend_ff         <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= (state_ff == S_DONE);
         edge_go_ff <= (state_ff == S_EDGE);
         pend_ff    <= pend_ff + 2'(edge_go_ff) - 2'(cross_valid);
         case (state_ff)
            S_IDLE: if (start) begin
               req_ff   <= req_item;
               area_ff  <= '0;
               rsp_item <= '{found: 1'b0, area_index: 4'd0, status: load_status};
               case (req_item.operation)
                  OP_CLEAR: begin
                     area_count_ff   <= '0;
                     vertex_count_ff <= '0;
                     last_total_ff   <= '0;
                  end
                  OP_OPEN:
                     if (load_status == ST_OK) begin
                        area_count_ff <= area_count_ff + 1'b1;
                        last_total_ff <= '0;
                     end
                  OP_VERTEX:
                     if (load_status == ST_OK) begin
                        vertex_count_ff <= vertex_count_ff + 1'b1;
                        last_total_ff   <= last_total_ff + 1'b1;
                     end
                  default: ;
               endcase
            end
            S_BOX: begin
               first_ff  <= span_rd_ff[VW-1:0];
               total_ff  <= span_rd_ff[VC+VW-1:VW];
               k_ff      <= '0;
               inside_ff <= 1'b0;
               if (!(in_box && span_rd_ff[VC+VW-1:VW] != 0)) area_ff <= area_ff + 1'b1;
            end
            S_PRIME: k_ff <= k_ff + 1'b1;
            // every vertex cycle launches one edge; the last one is the closing edge
            S_EDGE: begin
               vfirst_ff <= (k_ff == total_ff);
               if (k_ff == 1) first_pt_ff <= vert_rd_ff;
               a_ff <= vert_rd_ff;
               if (k_ff != total_ff) k_ff <= k_ff + 1'b1;
            end
            S_DRAIN: if (state_in != S_DRAIN) begin
               if (inside_ff)
                  rsp_item <= '{found: 1'b1, area_index: 4'(area_ff), status: ST_OK};
               else
                  area_ff <= area_ff + 1'b1;
            end
            default: ;
         endcase
         if (cross_valid && edge_cross) inside_ff <= !inside_ff;
      end
   end

   property p_strobe_one;
      @(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe;
   endproperty
   a_strobe_one: assert property (p_strobe_one) else $error("double strobe");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      area_count_ff <= AC'(MAX_AREAS)) else $error("area count overflow");
   a_vert_cap: assert property (@(posedge clock) disable iff (reset)
      vertex_count_ff <= VC'(MAX_VERTICES)) else $error("vertex count overflow");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("busy at result");
endmodule
